@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
// no dependencies; expects clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property checked on every clock outside reset
`define DTQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define DTQ_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/dtq_pkg.sv @@
// types and constants of the deadline timer queue
// used by dtq_cell and deadline_timer_queue_core
package dtq_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W   = 6;
  localparam logic [30:0] TILL_MAX = 31'h7FFF_FFFF;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } dtq_cmd_t;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_FIRE   = 2'd1,
    KIND_STATUS = 2'd2
  } dtq_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_TICK,
    ST_EMIT
  } dtq_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP
  } dtq_cell_op_t;

  typedef struct packed {
    dtq_cell_op_t op;
    logic         occupied;
    logic         prev_stay;
  } dtq_cell_ctrl_t;

  typedef struct packed {
    logic [3:0]  timer_type;
    logic [31:0] owner_tag;
    logic [31:0] duration;
  } dtq_meta_t;

  typedef struct packed {
    dtq_cmd_t    cmd;
    logic [3:0]  timer_type;
    logic [31:0] owner_tag;
    logic [31:0] offset_ms;
  } dtq_in_t;

  typedef struct packed {
    dtq_kind_t   kind;
    logic [31:0] timer_id;
    logic [3:0]  fired_type;
    logic [31:0] fired_tag;
    logic [31:0] fired_duration;
    logic [30:0] till_next_ms;
    logic        queue_full;
    logic        last;
  } dtq_out_t;

endpackage

@@ hw/rtl/deadline_timer_queue_core.sv @@
// channel   dir  handshake            payload
// in_       in   in_valid / in_stall  dtq_in_t: add or tick command
// out_      out  out_valid / out_stall dtq_out_t: add ack, fired timer or status
// an add passes the insert and emit steps, and its result is registered in the emit step;
// a tick alternates tick and emit steps, the head cell popping once for each fired timer
// one transaction in flight; in_stall is high until its last result is registered
// reset clears count, id and time; the cell chain needs no clearing pass
// out_stall holds the sequencer in its emit step without losing a result
// depends on dtq_pkg, dtq_cell and assert_macros.svh
`include "assert_macros.svh"

module deadline_timer_queue_core import dtq_pkg::*; #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TIME_BITS   = 48
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dtq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output dtq_out_t out_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  dtq_state_t           state_r, state_nxt;
  logic [TIME_BITS-1:0] now_r;
  logic [31:0]          next_id_r;
  logic [CNT_W-1:0]     count_r;
  logic [RES_CNT_W-1:0] n_r;
  logic [TIME_BITS-1:0] new_dl_r;
  dtq_meta_t            new_meta_r;
  dtq_kind_t            res_kind_r;
  logic                 res_full_r;
  logic [31:0]          res_id_r;
  dtq_meta_t            res_meta_r;
  logic                 out_valid_r;
  dtq_out_t             out_data_r;

  logic [TIME_BITS-1:0] cell_dl   [QUEUE_DEPTH];
  dtq_meta_t            cell_meta [QUEUE_DEPTH];
  logic                 cell_stay [QUEUE_DEPTH];
  dtq_cell_ctrl_t       cell_ctrl [QUEUE_DEPTH];
  dtq_cell_op_t         cell_op;

  logic                 in_accept;
  logic                 out_load;
  logic                 emit_last;
  logic                 head_due;
  logic                 is_full;
  logic [TIME_BITS-1:0] head_diff;
  logic [30:0]          till_next;

  // sorted cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [TIME_BITS-1:0] l_dl, r_dl;
    dtq_meta_t            l_meta, r_meta;

    if (i == 0) begin : g_first
      assign l_dl                 = new_dl_r;
      assign l_meta               = new_meta_r;
      assign cell_ctrl[i].prev_stay = 1'b1;
    end else begin : g_mid
      assign l_dl                 = cell_dl[i-1];
      assign l_meta               = cell_meta[i-1];
      assign cell_ctrl[i].prev_stay = cell_stay[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_dl   = cell_dl[i];
      assign r_meta = cell_meta[i];
    end else begin : g_inner
      assign r_dl   = cell_dl[i+1];
      assign r_meta = cell_meta[i+1];
    end

    assign cell_ctrl[i].op       = cell_op;
    assign cell_ctrl[i].occupied = CNT_W'(i) < count_r;

    dtq_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .new_dl    (new_dl_r),
      .new_meta  (new_meta_r),
      .left_dl   (l_dl),
      .left_meta (l_meta),
      .right_dl  (r_dl),
      .right_meta(r_meta),
      .stay      (cell_stay[i]),
      .dl        (cell_dl[i]),
      .meta      (cell_meta[i])
    );
  end

  // head status
  assign head_due  = (count_r != '0) && (cell_dl[0] <= now_r);
  assign is_full   = count_r == CNT_W'(QUEUE_DEPTH);
  assign head_diff = cell_dl[0] - now_r;

  always_comb begin
    if (count_r == '0) begin
      till_next = TILL_MAX;
    end else if (head_due) begin
      till_next = '0;
    end else if (|head_diff[TIME_BITS-1:31]) begin
      till_next = TILL_MAX;
    end else begin
      till_next = head_diff[30:0];
    end
  end

  assign emit_last = (res_kind_r != KIND_FIRE) ||
                     !(head_due && (n_r < RES_CNT_W'(MAX_RESULTS)));
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cell_op   = CELL_HOLD;
    in_stall  = 1'b1;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = (in_data.cmd == CMD_TICK) ? ST_TICK : ST_INSERT;
        end
      end
      ST_INSERT: begin
        if (!is_full) begin
          cell_op = CELL_INSERT;
        end
        state_nxt = ST_EMIT;
      end
      ST_TICK: begin
        if (head_due) begin
          cell_op = CELL_POP;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = emit_last ? ST_IDLE : ST_TICK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      next_id_r   <= '0;
      count_r     <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        n_r <= '0;
        if (in_data.cmd == CMD_TICK) begin
          now_r <= now_r + TIME_BITS'(1);
        end
      end
      if (state_r == ST_INSERT && !is_full) begin
        next_id_r <= next_id_r + 32'd1;
        count_r   <= count_r + CNT_W'(1);
      end
      if (state_r == ST_TICK && head_due) begin
        count_r <= count_r - CNT_W'(1);
        n_r     <= n_r + RES_CNT_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      new_dl_r              <= now_r + TIME_BITS'(in_data.offset_ms);
      new_meta_r.timer_type <= in_data.timer_type;
      new_meta_r.owner_tag  <= in_data.owner_tag;
      new_meta_r.duration   <= in_data.offset_ms;
    end
    case (state_r)
      ST_INSERT: begin
        res_kind_r <= is_full ? KIND_STATUS : KIND_ADD;
        res_full_r <= is_full;
        res_id_r   <= is_full ? 32'd0 : next_id_r;
        res_meta_r <= '0;
      end
      ST_TICK: begin
        res_kind_r <= head_due ? KIND_FIRE : KIND_STATUS;
        res_full_r <= 1'b0;
        res_id_r   <= 32'd0;
        res_meta_r <= head_due ? cell_meta[0] : '0;
      end
      default: begin
        res_kind_r <= res_kind_r;
      end
    endcase
    if (out_load) begin
      out_data_r.kind           <= res_kind_r;
      out_data_r.timer_id       <= res_id_r;
      out_data_r.fired_type     <= res_meta_r.timer_type;
      out_data_r.fired_tag      <= res_meta_r.owner_tag;
      out_data_r.fired_duration <= res_meta_r.duration;
      out_data_r.till_next_ms   <= till_next;
      out_data_r.queue_full     <= res_full_r;
      out_data_r.last           <= emit_last;
    end
  end

  `DTQ_NEVER(a_count_bound, count_r > CNT_W'(QUEUE_DEPTH), "entry count above depth")
  `DTQ_NEVER(a_burst_bound, n_r > RES_CNT_W'(MAX_RESULTS), "fired count above limit")
  `DTQ_ASSERT(a_sorted_head, (count_r >= CNT_W'(2)) |-> (cell_dl[0] <= cell_dl[1]), "head unsorted")
  `DTQ_ASSERT(a_last_idle, (out_load && emit_last) |=> (state_r == ST_IDLE), "last not idle")
  `DTQ_ASSERT(a_pop_nonempty, (cell_op == CELL_POP) |-> (count_r != '0), "pop from empty chain")

endmodule

@@ hw/rtl/dtq_cell.sv @@
// one slot of the sorted timer chain: holds a deadline and its timer data
// depends on dtq_pkg; shifts right on insert, left on pop
module dtq_cell import dtq_pkg::*; #(
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  dtq_cell_ctrl_t       ctrl,
  input  logic [TIME_BITS-1:0] new_dl,
  input  dtq_meta_t            new_meta,
  input  logic [TIME_BITS-1:0] left_dl,
  input  dtq_meta_t            left_meta,
  input  logic [TIME_BITS-1:0] right_dl,
  input  dtq_meta_t            right_meta,
  output logic                 stay,
  output logic [TIME_BITS-1:0] dl,
  output dtq_meta_t            meta
);

  logic [TIME_BITS-1:0] dl_r, dl_nxt;
  dtq_meta_t            meta_r, meta_nxt;

  assign stay = ctrl.occupied && (dl_r <= new_dl);
  assign dl   = dl_r;
  assign meta = meta_r;

  always_comb begin
    dl_nxt   = dl_r;
    meta_nxt = meta_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (!stay) begin
          if (ctrl.prev_stay) begin
            dl_nxt   = new_dl;
            meta_nxt = new_meta;
          end else begin
            dl_nxt   = left_dl;
            meta_nxt = left_meta;
          end
        end
      end
      CELL_POP: begin
        dl_nxt   = right_dl;
        meta_nxt = right_meta;
      end
      default: begin
        dl_nxt   = dl_r;
        meta_nxt = meta_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dl_r   <= dl_nxt;
    meta_r <= meta_nxt;
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// testbench for deadline_timer_queue_core: directed table, then random add and tick episodes
// checked against a sorted timer store kept here; depends on dtq_pkg and the core rtl

module testbench;
  import dtq_pkg::*;

  localparam int DEPTH       = 32;
  localparam int TBITS       = 48;
  localparam int RAND_ITEMS  = 340;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    dtq_in_t  stim;
    logic     typed;
    dtq_out_t want;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  dtq_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  dtq_out_t out_data;

  // timer store copy
  logic [TBITS-1:0] now_ms;
  logic [31:0]      id_seq;
  int               n_pending;
  logic [TBITS-1:0] due_at [DEPTH];
  logic [3:0]       type_of [DEPTH];
  logic [31:0]      tag_of [DEPTH];
  logic [31:0]      dur_of [DEPTH];

  dtq_out_t step_results [$];
  dtq_out_t awaited_results [$];
  dir_row_t dir_tab [$];

  int  fail_count;
  int  sent_items;
  int  hold_left;
  int  stuck_adds;
  logic idle_on;

  deadline_timer_queue_core #(
    .QUEUE_DEPTH(DEPTH),
    .TIME_BITS  (TBITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [30:0] ms_to_next();
    logic [TBITS-1:0] gap;
    if (n_pending == 0) return TILL_MAX;
    if (now_ms >= due_at[0]) return '0;
    gap = due_at[0] - now_ms;
    if (gap > TBITS'(TILL_MAX)) return TILL_MAX;
    return gap[30:0];
  endfunction

  task automatic timer_store_step(input dtq_in_t d);
    dtq_out_t         r;
    logic [TBITS-1:0] dl;
    int               pos;
    int               i;
    int               n;
    step_results.delete();
    r = '0;
    if (d.cmd == CMD_ADD) begin
      if (n_pending >= DEPTH) begin
        r.kind = KIND_STATUS;
        r.queue_full = 1'b1;
        r.till_next_ms = ms_to_next();
        r.last = 1'b1;
        step_results.push_back(r);
      end else begin
        dl = now_ms + TBITS'(d.offset_ms);
        pos = 0;
        while (pos < n_pending && due_at[pos] <= dl) pos++;
        for (i = n_pending; i > pos; i--) begin
          due_at[i]  = due_at[i-1];
          type_of[i] = type_of[i-1];
          tag_of[i]  = tag_of[i-1];
          dur_of[i]  = dur_of[i-1];
        end
        due_at[pos]  = dl;
        type_of[pos] = d.timer_type;
        tag_of[pos]  = d.owner_tag;
        dur_of[pos]  = d.offset_ms;
        n_pending++;
        r.kind = KIND_ADD;
        r.timer_id = id_seq;
        r.till_next_ms = ms_to_next();
        r.last = 1'b1;
        step_results.push_back(r);
        id_seq++;
      end
    end else begin
      now_ms = now_ms + 1'b1;
      n = 0;
      while (n < MAX_RESULTS && n_pending > 0 && due_at[0] <= now_ms) begin
        r = '0;
        r.kind = KIND_FIRE;
        r.fired_type = type_of[0];
        r.fired_tag = tag_of[0];
        r.fired_duration = dur_of[0];
        for (i = 1; i < n_pending; i++) begin
          due_at[i-1]  = due_at[i];
          type_of[i-1] = type_of[i];
          tag_of[i-1]  = tag_of[i];
          dur_of[i-1]  = dur_of[i];
        end
        n_pending--;
        r.till_next_ms = ms_to_next();
        step_results.push_back(r);
        n++;
      end
      if (n == 0) begin
        r = '0;
        r.kind = KIND_STATUS;
        r.till_next_ms = ms_to_next();
        r.last = 1'b1;
        step_results.push_back(r);
      end else begin
        step_results[step_results.size()-1].last = 1'b1;
      end
    end
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic drive_item(input dtq_in_t d, input logic typed, input dtq_out_t want);
    while (idle_on && $urandom_range(99) < 23) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = d;
    do @(posedge clk); while (in_stall);
    timer_store_step(d);
    if (typed) awaited_results.push_back(want);
    else foreach (step_results[k]) awaited_results.push_back(step_results[k]);
    sent_items++;
    @(negedge clk);
  endtask

  function automatic dtq_in_t add_item(input logic [31:0] off);
    dtq_in_t d;
    d.cmd = CMD_ADD;
    d.timer_type = 4'($urandom_range(0, 15));
    d.owner_tag = $urandom;
    d.offset_ms = off;
    return d;
  endfunction

  function automatic dtq_in_t tick_item();
    dtq_in_t d;
    d.cmd = CMD_TICK;
    d.timer_type = 4'($urandom_range(0, 15));
    d.owner_tag = $urandom;
    d.offset_ms = $urandom;
    return d;
  endfunction

  task automatic send_add(input logic [31:0] off);
    drive_item(add_item(off), 1'b0, '0);
  endtask

  task automatic send_tick();
    drive_item(tick_item(), 1'b0, '0);
  endtask

  // small offsets mostly, a few far ones that never drain
  function automatic logic [31:0] pick_offset(input int hi);
    if (stuck_adds < 6 && $urandom_range(39) == 0) begin
      stuck_adds++;
      return $urandom | 32'h8000_0000;
    end
    return 32'($urandom_range(0, hi));
  endfunction

  function automatic dir_row_t drow(input dtq_cmd_t c, input logic [3:0] ty,
                                    input logic [31:0] tag, input logic [31:0] off,
                                    input logic typed, input dtq_kind_t k,
                                    input logic [31:0] id, input logic [30:0] till,
                                    input logic full);
    dir_row_t row;
    row.stim.cmd = c;
    row.stim.timer_type = ty;
    row.stim.owner_tag = tag;
    row.stim.offset_ms = off;
    row.typed = typed;
    row.want = '0;
    row.want.kind = k;
    row.want.timer_id = id;
    row.want.till_next_ms = till;
    row.want.queue_full = full;
    row.want.last = 1'b1;
    return row;
  endfunction

  // receiver side
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = idle_on && ($urandom_range(99) < 23);
      end
    end
  end

  always @(posedge clk) begin
    dtq_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        if (fail_count < 10) $display("unexpected result %h", out_data);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.kind !== want.kind || out_data.timer_id !== want.timer_id ||
            out_data.fired_type !== want.fired_type ||
            out_data.fired_tag !== want.fired_tag ||
            out_data.fired_duration !== want.fired_duration ||
            out_data.till_next_ms !== want.till_next_ms ||
            out_data.queue_full !== want.queue_full || out_data.last !== want.last) begin
          if (fail_count < 10)
            $display("result differs: expected kind=%0d id=%h type=%h tag=%h dur=%h ",
                     want.kind, want.timer_id, want.fired_type, want.fired_tag,
                     want.fired_duration,
                     "till=%h full=%b last=%b, got kind=%0d id=%h type=%h tag=%h ",
                     want.till_next_ms, want.queue_full, want.last,
                     out_data.kind, out_data.timer_id, out_data.fired_type,
                     out_data.fired_tag,
                     "dur=%h till=%h full=%b last=%b",
                     out_data.fired_duration, out_data.till_next_ms,
                     out_data.queue_full, out_data.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int cyc;
    for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk);
    $display("deadline_timer_queue_core: mismatch");
    $finish;
  end

  initial begin
    int   ep;
    int   k;
    int   reps;
    int   off_eq;
    logic held;
    logic paused;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    idle_on = 1'b1;
    hold_left = 0;
    fail_count = 0;
    sent_items = 0;
    stuck_adds = 0;
    now_ms = '0;
    id_seq = '0;
    n_pending = 0;
    held = 1'b0;
    paused = 1'b0;

    dir_tab.push_back(drow(CMD_TICK, 4'h0, 32'h0, 32'h0, 1'b1, KIND_STATUS, 0, TILL_MAX,
                           1'b0));
    dir_tab.push_back(drow(CMD_ADD, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, KIND_ADD, 0,
                           TILL_MAX, 1'b0));
    dir_tab.push_back(drow(CMD_ADD, 4'h0, 32'h0, 32'h0, 1'b1, KIND_ADD, 1, 31'd0, 1'b0));
    dir_tab.push_back(drow(CMD_TICK, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, KIND_FIRE,
                           0, 31'd0, 1'b0));
    dir_tab.push_back(drow(CMD_ADD, 4'h5, 32'hA5A5_A5A5, 32'd3, 1'b1, KIND_ADD, 2, 31'd3,
                           1'b0));
    // same deadline, must fire after the previous one
    dir_tab.push_back(drow(CMD_ADD, 4'hA, 32'h5A5A_5A5A, 32'd3, 1'b1, KIND_ADD, 3, 31'd3,
                           1'b0));
    dir_tab.push_back(drow(CMD_ADD, 4'h3, 32'h1234_5678, 32'd1, 1'b1, KIND_ADD, 4, 31'd1,
                           1'b0));
    dir_tab.push_back(drow(CMD_TICK, 4'h0, 32'h0, 32'h0, 1'b0, KIND_FIRE, 0, 31'd0, 1'b0));
    dir_tab.push_back(drow(CMD_TICK, 4'h0, 32'h0, 32'h0, 1'b1, KIND_STATUS, 0, 31'd1,
                           1'b0));
    dir_tab.push_back(drow(CMD_TICK, 4'h0, 32'h0, 32'h0, 1'b0, KIND_FIRE, 0, 31'd0, 1'b0));
    dir_tab.push_back(drow(CMD_ADD, 4'h6, 32'h0F0F_0F0F, 32'h7FFF_FFFF, 1'b1, KIND_ADD, 5,
                           TILL_MAX, 1'b0));
    dir_tab.push_back(drow(CMD_ADD, 4'h9, 32'hF0F0_F0F0, 32'h7FFF_FFFE, 1'b1, KIND_ADD, 6,
                           31'h7FFF_FFFE, 1'b0));
    dir_tab.push_back(drow(CMD_ADD, 4'hC, 32'h0, 32'h8000_0000, 1'b1, KIND_ADD, 7,
                           31'h7FFF_FFFE, 1'b0));
    dir_tab.push_back(drow(CMD_TICK, 4'h0, 32'h0, 32'h0, 1'b0, KIND_STATUS, 0, 31'd0,
                           1'b0));
    dir_tab.push_back(drow(CMD_ADD, 4'h1, 32'h1, 32'h0, 1'b1, KIND_ADD, 8, 31'd0, 1'b0));
    dir_tab.push_back(drow(CMD_TICK, 4'h0, 32'h0, 32'h0, 1'b0, KIND_FIRE, 0, 31'd0, 1'b0));

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_tab[j]) drive_item(dir_tab[j].stim, dir_tab[j].typed, dir_tab[j].want);

    ep = 0;
    while (sent_items < dir_tab.size() + RAND_ITEMS) begin
      if (!held && sent_items > 120) begin
        hold_left = 300;
        held = 1'b1;
      end
      if (!paused && sent_items > 210) begin
        in_valid = 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        @(negedge clk);
        paused = 1'b1;
      end
      idle_on = !(sent_items >= 250 && sent_items < 330);

      case ($urandom_range(0, 9))
        0, 1: ep = 0;
        2, 3, 4, 5, 6: ep = 1;
        7, 8: ep = 2;
        default: ep = 3;
      endcase
      if (sent_items == dir_tab.size()) ep = 0;

      case (ep)
        0: begin
          // fill the store, overflow it, then fire the batch
          while (n_pending < DEPTH) send_add(32'($urandom_range(0, 3)));
          reps = $urandom_range(2, 3);
          for (k = 0; k < reps; k++) send_add(32'($urandom_range(0, 3)));
          for (k = 0; k < 5; k++) send_tick();
        end
        1: begin
          reps = $urandom_range(10, 20);
          for (k = 0; k < reps; k++) begin
            if ($urandom_range(1)) send_add(pick_offset(12));
            else send_tick();
          end
        end
        2: begin
          off_eq = $urandom_range(1, 6);
          reps = $urandom_range(4, 8);
          for (k = 0; k < reps; k++) send_add(32'(off_eq));
          for (k = 0; k < off_eq + 2; k++) send_tick();
        end
        default: begin
          reps = $urandom_range(1, 4);
          for (k = 0; k < reps; k++) begin
            if ($urandom_range(3) == 0) send_add(pick_offset(32'hFFFF));
            else send_tick();
          end
        end
      endcase
    end

    in_valid = 1'b0;
    idle_on = 1'b1;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("deadline_timer_queue_core: match");
    end else begin
      $display("deadline_timer_queue_core: mismatch");
    end
    $finish;
  end

endmodule
